// ===== rtl/bbrt_pkg.sv =====
// Package with the types, codes and sizes shared by the renumbering table.
package bbrt_pkg;

   localparam int PHYS_W     = 12;
   localparam int INT_W      = 10;
   localparam int CNT_W      = 11;
   localparam int IDX_W      = 13;
   localparam int PHYS_SPACE = 4096;
   localparam int INT_SPACE  = 1024;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_PERM = 2'd1;

   typedef enum logic [2:0] {
      OP_SET         = 3'd0,
      OP_LOOKUP_PHYS = 3'd1,
      OP_LOOKUP_INT  = 3'd2,
      OP_PERM        = 3'd3,
      OP_CLEAR       = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_LOOK_EVAL,
      ST_LINK_RD,
      ST_LINK_EVAL,
      ST_LINK_WR,
      ST_PERM_EVAL,
      ST_COPY,
      ST_WALK_RD,
      ST_WALK_IDX,
      ST_WALK_EVAL,
      ST_WALK_NEXT,
      ST_SEEN_CLR,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]        op;
      logic [PHYS_W-1:0] phys_num;
      logic [INT_W-1:0]  int_num;
      logic [INT_W-1:0]  old_int_num;
      logic              last;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [INT_W-1:0]  mapped_internal;
      logic [PHYS_W-1:0] mapped_physical;
      logic [1:0]        status;
      logic              table_full;
      logic              table_empty;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [INT_W-1:0] num;
   } p2i_entry_type;

   typedef struct packed {
      logic              valid;
      logic [PHYS_W-1:0] num;
   } i2p_entry_type;

endpackage

// ===== rtl/bidirectional_bus_renumbering_table_unit.sv =====
// Top level of the bidirectional bus renumbering table.
// A word is taken at a clock edge where start is high and busy is low. Busy stays
// high until the cycle that shows its result word; every word gives exactly one result,
// shown on rsp_data for a single cycle with rsp_valid high. The receiver cannot stall.
// A lookup goes from decode to an evaluate state; a set pair goes through the link
// states (a pair with physical number 0 is skipped), a permutation word that is not
// last records its element, and clear sweeps both mapping tables and the seen marks.
// A last permutation word, if the permutation is valid, snapshots the internal table
// and walks its elements through the mirror tables to renumber them; valid or not, it
// then wipes all 1024 seen marks. Throughput is one word at a time; each set reads
// and writes the two mirror memories, and each lookup reads one of them.
// After reset the block sweeps the physical table, one entry a cycle, with busy high,
// then accepts words.
module bidirectional_bus_renumbering_table_unit
   import bbrt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   state_type state_ff, state_in;
   req_type req_ff, req_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in, extent_ff, extent_in, len_ff, len_in;
   logic bad_ff, bad_in;
   logic [INT_W-1:0] max_ff, max_in;
   logic [PHYS_W-1:0] link_ph_ff, link_ph_in;
   logic [INT_W-1:0] link_in_ff, link_in_in;
   logic res_found_ff, res_found_in;
   logic [INT_W-1:0] res_mi_ff, res_mi_in;
   logic [PHYS_W-1:0] res_mp_ff, res_mp_in;
   logic [1:0] res_status_ff, res_status_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   p2i_entry_type p2i_mem [PHYS_SPACE];
   i2p_entry_type i2p_mem [INT_SPACE];
   i2p_entry_type snap_mem [INT_SPACE];
   logic [INT_W-1:0] perm_mem [INT_SPACE];
   logic seen_mem [INT_SPACE];

   p2i_entry_type p2i_rdata, p2i_wdata;
   i2p_entry_type i2p_rdata, i2p_wdata, snap_rdata, snap_wdata;
   logic [INT_W-1:0] perm_rdata, perm_wdata;
   logic seen_rdata, seen_wdata;
   logic p2i_we, i2p_we, snap_we, perm_we, seen_we;
   logic [PHYS_W-1:0] p2i_waddr, p2i_raddr;
   logic [INT_W-1:0] i2p_waddr, i2p_raddr, snap_waddr, snap_raddr;
   logic [INT_W-1:0] perm_waddr, perm_raddr, seen_waddr, seen_raddr;

   logic same_pair, sweep_low, sweep_end, seen_end, perm_ok, bad_next;
   logic [CNT_W-1:0] len_next;
   logic [INT_W-1:0] max_next;
   logic walking;

   assign walking   = (req_ff.op == OP_PERM);
   assign same_pair = p2i_rdata.valid && (p2i_rdata.num == link_in_ff);
   assign sweep_low = (idx_ff < IDX_W'(INT_SPACE));
   assign sweep_end = (idx_ff == IDX_W'(PHYS_SPACE - 1));
   assign seen_end  = (idx_ff == IDX_W'(INT_SPACE - 1));
   assign bad_next  = bad_ff || len_ff[CNT_W-1] || seen_rdata;
   assign len_next  = len_ff[CNT_W-1] ? len_ff : len_ff + CNT_W'(1);
   assign max_next  = (req_ff.old_int_num > max_ff) ? req_ff.old_int_num : max_ff;
   assign perm_ok   = !bad_next && (CNT_W'(max_next) < len_next);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (sweep_end) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (req_ff.op)
               OP_SET: begin
                  state_in = (req_ff.phys_num == '0) ? ST_DONE : ST_LINK_EVAL;
               end
               OP_LOOKUP_PHYS, OP_LOOKUP_INT: state_in = ST_LOOK_EVAL;
               OP_PERM:  state_in = ST_PERM_EVAL;
               OP_CLEAR: state_in = ST_CLEAR;
               default:  state_in = ST_DONE;
            endcase
         end
         ST_LOOK_EVAL: state_in = ST_DONE;
         ST_LINK_RD: state_in = ST_LINK_EVAL;
         ST_LINK_EVAL: begin
            if (!same_pair) state_in = ST_LINK_WR;
            else state_in = walking ? ST_WALK_NEXT : ST_DONE;
         end
         ST_LINK_WR: state_in = walking ? ST_WALK_NEXT : ST_DONE;
         ST_PERM_EVAL: begin
            if (!req_ff.last) state_in = ST_DONE;
            else state_in = perm_ok ? ST_COPY : ST_SEEN_CLR;
         end
         ST_COPY: begin
            if (idx_ff == IDX_W'(len_ff)) state_in = ST_WALK_RD;
         end
         ST_WALK_RD: state_in = ST_WALK_IDX;
         ST_WALK_IDX: state_in = ST_WALK_EVAL;
         ST_WALK_EVAL: begin
            if (snap_rdata.valid && snap_rdata.num != '0) state_in = ST_LINK_RD;
            else state_in = ST_WALK_NEXT;
         end
         ST_WALK_NEXT: begin
            if (idx_ff == IDX_W'(len_ff) - IDX_W'(1)) state_in = ST_SEEN_CLR;
            else state_in = ST_WALK_RD;
         end
         ST_SEEN_CLR: begin
            if (seen_end) state_in = ST_DONE;
         end
         ST_CLEAR: begin
            if (sweep_end) state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_in        = req_ff;
      idx_in        = '0;
      count_in      = count_ff;
      extent_in     = extent_ff;
      len_in        = len_ff;
      bad_in        = bad_ff;
      max_in        = max_ff;
      link_ph_in    = link_ph_ff;
      link_in_in    = link_in_ff;
      res_found_in  = res_found_ff;
      res_mi_in     = res_mi_ff;
      res_mp_in     = res_mp_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      p2i_we = 1'b0; p2i_waddr = link_ph_ff; p2i_wdata = '0;
      i2p_we = 1'b0; i2p_waddr = link_in_ff; i2p_wdata = '0;
      snap_we = 1'b0; snap_waddr = idx_ff[INT_W-1:0] - INT_W'(1); snap_wdata = i2p_rdata;
      perm_we = 1'b0; perm_waddr = len_ff[INT_W-1:0]; perm_wdata = req_ff.old_int_num;
      seen_we = 1'b0; seen_waddr = req_ff.old_int_num; seen_wdata = 1'b1;
      p2i_raddr  = (state_ff == ST_LINK_RD) ? link_ph_ff : req_ff.phys_num;
      i2p_raddr  = req_ff.int_num;
      if (state_ff == ST_LINK_RD) i2p_raddr = link_in_ff;
      if (state_ff == ST_COPY) i2p_raddr = idx_ff[INT_W-1:0];
      seen_raddr = req_ff.old_int_num;
      perm_raddr = idx_ff[INT_W-1:0];
      snap_raddr = perm_rdata;

      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            idx_in = sweep_end ? '0 : idx_ff + IDX_W'(1);
            p2i_we = 1'b1;
            p2i_waddr = idx_ff[PHYS_W-1:0];
            i2p_we = sweep_low;
            i2p_waddr = idx_ff[INT_W-1:0];
            seen_we = sweep_low;
            seen_waddr = idx_ff[INT_W-1:0];
            seen_wdata = 1'b0;
            count_in = '0;
            extent_in = '0;
            len_in = '0;
            bad_in = 1'b0;
            max_in = '0;
         end
         ST_IDLE: begin
            if (start) req_in = req_data;
         end
         ST_DECODE: begin
            res_found_in  = 1'b0;
            res_mi_in     = '0;
            res_mp_in     = '0;
            res_status_in = STATUS_OK;
            link_ph_in    = req_ff.phys_num;
            link_in_in    = req_ff.int_num;
         end
         ST_LOOK_EVAL: begin
            if (req_ff.op == OP_LOOKUP_PHYS) begin
               if (req_ff.phys_num != '0 && p2i_rdata.valid) begin
                  res_found_in = 1'b1;
                  res_mi_in = p2i_rdata.num;
               end
            end else if (i2p_rdata.valid) begin
               res_found_in = 1'b1;
               res_mp_in = i2p_rdata.num;
            end
         end
         ST_LINK_RD: idx_in = idx_ff;
         ST_LINK_EVAL: begin
            idx_in = idx_ff;
            if (!same_pair) begin
               i2p_we = p2i_rdata.valid;
               i2p_waddr = p2i_rdata.num;
               p2i_we = i2p_rdata.valid;
               p2i_waddr = i2p_rdata.num;
               count_in = count_ff - CNT_W'(p2i_rdata.valid) - CNT_W'(i2p_rdata.valid);
            end
         end
         ST_LINK_WR: begin
            idx_in = idx_ff;
            p2i_we = 1'b1;
            p2i_wdata = '{valid: 1'b1, num: link_in_ff};
            i2p_we = 1'b1;
            i2p_wdata = '{valid: 1'b1, num: link_ph_ff};
            count_in = count_ff + CNT_W'(1);
            if (CNT_W'(link_in_ff) + CNT_W'(1) > extent_ff) begin
               extent_in = CNT_W'(link_in_ff) + CNT_W'(1);
            end
         end
         ST_PERM_EVAL: begin
            perm_we = !len_ff[CNT_W-1];
            seen_we = 1'b1;
            len_in = len_next;
            bad_in = bad_next;
            max_in = max_next;
            if (req_ff.last) res_status_in = perm_ok ? STATUS_OK : STATUS_BAD_PERM;
         end
         ST_COPY: begin
            idx_in = (idx_ff == IDX_W'(len_ff)) ? '0 : idx_ff + IDX_W'(1);
            snap_we = (idx_ff != '0);
         end
         ST_WALK_RD, ST_WALK_IDX: idx_in = idx_ff;
         ST_WALK_EVAL: begin
            idx_in = idx_ff;
            link_ph_in = snap_rdata.num;
            link_in_in = idx_ff[INT_W-1:0];
         end
         ST_WALK_NEXT: begin
            idx_in = (idx_ff == IDX_W'(len_ff) - IDX_W'(1)) ? '0 : idx_ff + IDX_W'(1);
         end
         ST_SEEN_CLR: begin
            idx_in = seen_end ? '0 : idx_ff + IDX_W'(1);
            seen_we = 1'b1;
            seen_waddr = idx_ff[INT_W-1:0];
            seen_wdata = 1'b0;
            if (seen_end) begin
               len_in = '0;
               bad_in = 1'b0;
               max_in = '0;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_data_in = '{found: res_found_ff, mapped_internal: res_mi_ff,
                            mapped_physical: res_mp_ff, status: res_status_ff,
                            table_full: (count_ff == extent_ff),
                            table_empty: (extent_ff == '0)};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (p2i_we) p2i_mem[p2i_waddr] <= p2i_wdata;
      p2i_rdata <= p2i_mem[p2i_raddr];
   end

   always_ff @(posedge clock) begin
      if (i2p_we) i2p_mem[i2p_waddr] <= i2p_wdata;
      i2p_rdata <= i2p_mem[i2p_raddr];
   end

   always_ff @(posedge clock) begin
      if (snap_we) snap_mem[snap_waddr] <= snap_wdata;
      snap_rdata <= snap_mem[snap_raddr];
   end

   always_ff @(posedge clock) begin
      if (perm_we) perm_mem[perm_waddr] <= perm_wdata;
      perm_rdata <= perm_mem[perm_raddr];
   end

   always_ff @(posedge clock) begin
      if (seen_we) seen_mem[seen_waddr] <= seen_wdata;
      seen_rdata <= seen_mem[seen_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         idx_ff       <= '0;
         count_ff     <= '0;
         extent_ff    <= '0;
         len_ff       <= '0;
         bad_ff       <= 1'b0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         extent_ff    <= extent_in;
         len_ff       <= len_in;
         bad_ff       <= bad_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      link_ph_ff    <= link_ph_in;
      link_in_ff    <= link_in_in;
      res_found_ff  <= res_found_in;
      res_mi_ff     <= res_mi_in;
      res_mp_ff     <= res_mp_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted word did not raise busy.");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DONE))
      else $error("Result strobe without a finished word.");
   a_count_le_extent: assert property (@(posedge clock) disable iff (reset)
      count_ff <= extent_ff)
      else $error("Mapped count exceeds the internal extent.");
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CNT_W'(INT_SPACE))
      else $error("Permutation length beyond the internal space.");
`endif

endmodule

// ===== dv/tb_bidirectional_bus_renumbering_table_unit.sv =====
// Testbench for the bus renumbering table: directed table, then random words against a predictor.
`timescale 1ns / 100ps

module tb_bidirectional_bus_renumbering_table_unit
   import bbrt_pkg::*;
();

   localparam int NUM_RANDOM = 1330;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   bidirectional_bus_renumbering_table_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   logic [INT_W-1:0]  map_p2i [PHYS_SPACE];
   bit                val_p   [PHYS_SPACE];
   logic [PHYS_W-1:0] map_i2p [INT_SPACE];
   bit                val_i   [INT_SPACE];
   logic [PHYS_W-1:0] snap_p  [INT_SPACE];
   bit                snap_v  [INT_SPACE];
   logic [INT_W-1:0]  perm_buf [INT_SPACE];
   bit                seen    [INT_SPACE];
   int unsigned extent, mapped, perm_len;
   bit          perm_bad;

   rsp_type rsp_queue [$];
   int      error_count = 0;
   int      rsp_count = 0;
   int      word_count = 0;

   task automatic report(input string what, input rsp_type got, input rsp_type want);
      error_count++;
      $display("error %s: got %h want %h at %0t", what, got, want, $realtime);
   endtask

   function automatic void clear_tables();
      foreach (val_p[k]) val_p[k] = 1'b0;
      foreach (val_i[k]) val_i[k] = 1'b0;
      extent = 0;
      mapped = 0;
   endfunction

   function automatic void clear_stream();
      foreach (seen[k]) seen[k] = 1'b0;
      perm_len = 0;
      perm_bad = 1'b0;
   endfunction

   function automatic void link(input logic [PHYS_W-1:0] ph, input logic [INT_W-1:0] in);
      logic [INT_W-1:0]  oi;
      logic [PHYS_W-1:0] op;
      if (val_p[ph] && map_p2i[ph] == in) return;
      if (val_p[ph]) begin
         oi = map_p2i[ph];
         val_p[ph] = 1'b0;
         if (val_i[oi]) begin
            val_i[oi] = 1'b0;
            mapped--;
         end
      end
      if (val_i[in]) begin
         op = map_i2p[in];
         val_i[in] = 1'b0;
         mapped--;
         val_p[op] = 1'b0;
      end
      map_p2i[ph] = in;
      val_p[ph] = 1'b1;
      map_i2p[in] = ph;
      val_i[in] = 1'b1;
      mapped++;
      if (in + 1 > extent) extent = in + 1;
   endfunction

   function automatic rsp_type renumber_predict(input req_type r);
      rsp_type o;
      bit ok;
      logic [INT_W-1:0] ob;
      o = '0;
      ob = r.old_int_num;
      case (r.op)
         OP_SET: if (r.phys_num != '0) link(r.phys_num, r.int_num);
         OP_LOOKUP_PHYS: if (r.phys_num != '0 && val_p[r.phys_num]) begin
            o.found = 1'b1;
            o.mapped_internal = map_p2i[r.phys_num];
         end
         OP_LOOKUP_INT: if (val_i[r.int_num]) begin
            o.found = 1'b1;
            o.mapped_physical = map_i2p[r.int_num];
         end
         OP_PERM: begin
            if (perm_len >= INT_SPACE) perm_bad = 1'b1;
            else perm_buf[perm_len++] = ob;
            if (seen[ob]) perm_bad = 1'b1;
            else seen[ob] = 1'b1;
            if (r.last) begin
               ok = !perm_bad;
               for (int k = 0; k < perm_len && ok; k++) if (!seen[k]) ok = 1'b0;
               if (ok) begin
                  snap_p = map_i2p;
                  snap_v = val_i;
                  for (int k = 0; k < perm_len; k++)
                     if (snap_v[perm_buf[k]] && snap_p[perm_buf[k]] != '0)
                        link(snap_p[perm_buf[k]], INT_W'(k));
                  o.status = STATUS_OK;
               end else o.status = STATUS_BAD_PERM;
               clear_stream();
            end
         end
         OP_CLEAR: begin
            clear_tables();
            clear_stream();
         end
         default: ;
      endcase
      o.table_full = (mapped == extent);
      o.table_empty = (extent == 0);
      return o;
   endfunction

   bit   idle_gaps = 1'b1;

   task automatic send(input req_type r);
      while (idle_gaps && $urandom_range(99) < 11) @(posedge clock);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      word_count++;
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_checked(input req_type r);
      rsp_queue.push_back(renumber_predict(r));
      send(r);
   endtask

   task automatic send_fixed(input req_type r, input rsp_type want);
      void'(renumber_predict(r));
      rsp_queue.push_back(want);
      send(r);
   endtask

   function automatic req_type mk(input logic [2:0] op, input int ph, input int in,
                                  input int ob, input bit lst);
      req_type r;
      r.op = op;
      r.phys_num = PHYS_W'(ph);
      r.int_num = INT_W'(in);
      r.old_int_num = INT_W'(ob);
      r.last = lst;
      return r;
   endfunction

   function automatic rsp_type mkr(input bit f, input int mi, input int mp,
                                   input logic [1:0] st, input bit fu, input bit em);
      rsp_type o;
      o.found = f;
      o.mapped_internal = INT_W'(mi);
      o.mapped_physical = PHYS_W'(mp);
      o.status = st;
      o.table_full = fu;
      o.table_empty = em;
      return o;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         rsp_count++;
         if (rsp_queue.size() == 0) report("unexpected word", rsp_data, '0);
         else begin
            if (rsp_data !== rsp_queue[0]) report("field mismatch", rsp_data, rsp_queue[0]);
            void'(rsp_queue.pop_front());
         end
      end
   end

   typedef struct {
      req_type r;
      bit      has_want;
      rsp_type want;
   } row_type;

   task automatic wait_drain();
      while (rsp_queue.size() != 0) @(posedge clock);
   endtask

   task automatic random_perm();
      int n, cut;
      int unsigned order [$];
      n = ($urandom_range(9) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 12);
      for (int k = 0; k < n; k++) order.push_back(k);
      order.shuffle();
      cut = $urandom_range(9);
      if (cut == 0) order[$urandom_range(n - 1)] = $urandom_range(1023);
      for (int k = 0; k < n; k++)
         send_checked(mk(OP_PERM, $urandom, $urandom, order[k], k == n - 1));
   endtask

   row_type rows [$];

   initial begin
      int pick;
      foreach (map_p2i[k]) map_p2i[k] = '0;
      foreach (map_i2p[k]) map_i2p[k] = '0;
      clear_tables();
      clear_stream();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      rows.push_back('{mk(OP_LOOKUP_PHYS, 0, 0, 0, 0), 1'b1,
                       mkr(0, 0, 0, STATUS_OK, 1, 1)});
      rows.push_back('{mk(OP_LOOKUP_INT, 0, 1023, 0, 0), 1'b1,
                       mkr(0, 0, 0, STATUS_OK, 1, 1)});
      rows.push_back('{mk(OP_SET, 0, 5, 0, 0), 1'b1, mkr(0, 0, 0, STATUS_OK, 1, 1)});
      rows.push_back('{mk(OP_SET, 4095, 1023, 0, 0), 1'b1, mkr(0, 0, 0, STATUS_OK, 0, 0)});
      rows.push_back('{mk(OP_LOOKUP_PHYS, 4095, 0, 0, 0), 1'b1,
                       mkr(1, 1023, 0, STATUS_OK, 0, 0)});
      rows.push_back('{mk(OP_LOOKUP_INT, 0, 1023, 0, 0), 1'b1,
                       mkr(1, 0, 4095, STATUS_OK, 0, 0)});
      rows.push_back('{mk(OP_SET, 4095, 1023, 0, 0), 1'b0, '0});
      rows.push_back('{mk(OP_SET, 1, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk(OP_SET, 1, 1023, 0, 0), 1'b0, '0});
      rows.push_back('{mk(OP_SET, 2, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk(OP_SET, 3, 1, 0, 0), 1'b0, '0});
      rows.push_back('{mk(OP_LOOKUP_PHYS, 4095, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk(OP_PERM, 0, 0, 1, 0), 1'b0, '0});
      rows.push_back('{mk(OP_PERM, 0, 0, 0, 1), 1'b0, '0});
      rows.push_back('{mk(OP_LOOKUP_INT, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk(OP_PERM, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk(OP_PERM, 0, 0, 0, 1), 1'b1,
                       mkr(0, 0, 0, STATUS_BAD_PERM, 0, 0)});
      rows.push_back('{mk(OP_PERM, 0, 0, 1023, 1), 1'b1,
                       mkr(0, 0, 0, STATUS_BAD_PERM, 0, 0)});
      rows.push_back('{mk(OP_PERM, 0, 0, 2, 1), 1'b1,
                       mkr(0, 0, 0, STATUS_BAD_PERM, 0, 0)});
      rows.push_back('{mk(3'd5, 4095, 1023, 1023, 1), 1'b0, '0});
      rows.push_back('{mk(3'd7, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk(OP_PERM, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk(OP_CLEAR, 0, 0, 0, 0), 1'b1, mkr(0, 0, 0, STATUS_OK, 1, 1)});
      rows.push_back('{mk(OP_LOOKUP_PHYS, 1, 0, 0, 0), 1'b1,
                       mkr(0, 0, 0, STATUS_OK, 1, 1)});
      foreach (rows[k])
         if (rows[k].has_want) send_fixed(rows[k].r, rows[k].want);
         else send_checked(rows[k].r);

      while (word_count < 24 + NUM_RANDOM) begin
         if (word_count > 300 && word_count < 500) idle_gaps = 1'b0;
         else idle_gaps = 1'b1;
         if (word_count > 700 && word_count < 712) wait_drain();
         pick = $urandom_range(99);
         if (pick < 40)
            send_checked(mk(OP_SET, ($urandom_range(3) == 0) ? $urandom : $urandom_range(40),
                            ($urandom_range(3) == 0) ? $urandom : $urandom_range(24), 0, 0));
         else if (pick < 55)
            send_checked(mk(OP_LOOKUP_PHYS, ($urandom_range(3) == 0) ? $urandom
                            : $urandom_range(40), $urandom, $urandom, 1'($urandom)));
         else if (pick < 70)
            send_checked(mk(OP_LOOKUP_INT, $urandom, ($urandom_range(3) == 0) ? $urandom
                            : $urandom_range(24), $urandom, 1'($urandom)));
         else if (pick < 90) random_perm();
         else if (pick < 93)
            send_checked(mk(OP_PERM, $urandom, $urandom, $urandom, 1'($urandom)));
         else if (pick < 95)
            send_checked(mk(OP_CLEAR, $urandom, $urandom, $urandom, 1'($urandom)));
         else send_checked(mk(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom,
                              1'($urandom)));
      end

      wait_drain();
      repeat (50) @(posedge clock);
      $display("Covered %0d words and %0d results: set pair, lookups, permutations, clear.",
               word_count, rsp_count);
      if (error_count == 0 && rsp_queue.size() == 0)
         $display("bidirectional_bus_renumbering_table_unit: match");
      else
         $display("bidirectional_bus_renumbering_table_unit: mismatch");
      $finish;
   end

   initial begin
      #(60_000_000);
      $display("bidirectional_bus_renumbering_table_unit: mismatch");
      $finish;
   end
endmodule
